[src/tie_pkg.sv]
// package for the tiny isa execute unit: payload structs, command and status codes
// and the request structs passed between the top level and its memories
// no dependencies
package tie_pkg;

   localparam int DATA_DEPTH_DEF = 1024;
   localparam int REG_COUNT = 8;
   localparam int RIDX_W = 3;
   localparam int WORD_W = 16;

   // instruction word fields
   localparam int FA_HI = 8;
   localparam int FA_LO = 6;
   localparam int FB_HI = 5;
   localparam int FB_LO = 3;
   localparam int FC_HI = 2;
   localparam int FC_LO = 0;

   typedef enum logic [3:0] {
      CMD_ADD = 4'd0,
      CMD_ADI = 4'd1,
      CMD_SHL = 4'd2,
      CMD_SUB = 4'd3,
      CMD_BRZ = 4'd4,
      CMD_JMP = 4'd5,
      CMD_LDI = 4'd6,
      CMD_LD  = 4'd7,
      CMD_SET = 4'd8,
      CMD_ST  = 4'd9,
      CMD_HLT = 4'd10
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_HALT    = 2'd1,
      STAT_ILLEGAL = 2'd2
   } stat_type;

   typedef struct packed {
      logic [3:0]        command;
      logic [WORD_W-1:0] instr;
      logic [WORD_W-1:0] next_word;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] next_pc;
      logic [1:0]        status;
      logic              reg_written;
      logic [RIDX_W-1:0] reg_index;
      logic [WORD_W-1:0] reg_value;
      logic              mem_written;
      logic [WORD_W-1:0] mem_address;
      logic [WORD_W-1:0] mem_data;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [RIDX_W-1:0] idx;
      logic [WORD_W-1:0] data;
   } rf_wr_type;

   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [WORD_W-1:0] addr;
      logic [WORD_W-1:0] wdata;
   } dmem_req_type;

endpackage

[src/tie_regfile.sv]
// register file: eight words, two synchronous read ports, one write port
// entries never written since reset read as zero; depends on tie_pkg
module tie_regfile (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [tie_pkg::RIDX_W-1:0]  rd_addr0,
   input  logic [tie_pkg::RIDX_W-1:0]  rd_addr1,
   output logic [tie_pkg::WORD_W-1:0]  rd_data0,
   output logic [tie_pkg::WORD_W-1:0]  rd_data1,
   input  tie_pkg::rf_wr_type          wr
);
   import tie_pkg::*;

   logic [WORD_W-1:0] mem_ff [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;
   logic [WORD_W-1:0] rd_data0_ff;
   logic [WORD_W-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.idx] <= wr.data;
      end
      if (rd_en) begin
         rd_data0_ff <= vld_ff[rd_addr0] ? mem_ff[rd_addr0] : '0;
         rd_data1_ff <= vld_ff[rd_addr1] ? mem_ff[rd_addr1] : '0;
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

[src/tie_dmem.sv]
// data memory: one synchronous read or write per cycle, address taken modulo depth
// zeroed by a sweep after reset; depends on tie_pkg
module tie_dmem #(
   parameter int DATA_DEPTH = tie_pkg::DATA_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tie_pkg::dmem_req_type      req,
   output logic [tie_pkg::WORD_W-1:0] rd_data,
   output logic                       ready
);
   import tie_pkg::*;

   localparam int AW = $clog2(DATA_DEPTH);
   localparam bit POW2 = ((DATA_DEPTH & (DATA_DEPTH - 1)) == 0);

   logic [WORD_W-1:0] mem_ff [DATA_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              clr_busy_ff;
   logic [AW-1:0]     clr_addr_ff;
   logic [AW-1:0]     idx;
   logic [AW-1:0]     wr_idx;
   logic [WORD_W-1:0] wr_data;
   logic              wr_en;

   generate
      if (POW2) begin : g_mask
         assign idx = req.addr[AW-1:0];
      end else begin : g_recip
         // exact for 16-bit addresses and depth >= 8: ceil(2^32 / depth) leaves an error below depth
         localparam logic [28:0] RECIP =
            29'(((64'd1 << 32) + 64'(DATA_DEPTH) - 64'd1) / 64'(DATA_DEPTH));
         localparam logic [15:0] DEPTH_W = 16'(DATA_DEPTH);
         logic [44:0] prod;
         logic [12:0] quo;
         logic [28:0] qd;
         logic [28:0] rem;
         assign prod = 45'(req.addr) * 45'(RECIP);
         assign quo  = prod[44:32];
         assign qd   = 29'(quo) * 29'(DEPTH_W);
         assign rem  = 29'(req.addr) - qd;
         assign idx  = rem[AW-1:0];
      end
   endgenerate

   // zeroing sweep, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(DATA_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign wr_en   = clr_busy_ff || req.wr;
   assign wr_idx  = clr_busy_ff ? clr_addr_ff : idx;
   assign wr_data = clr_busy_ff ? '0 : req.wdata;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
      if (req.rd) begin
         rd_data_ff <= mem_ff[idx];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clr_busy_ff;

endmodule

[src/tiny_isa_execute_unit.sv]
// tiny isa execute unit: executes one pre-decoded instruction per transfer
// channels: req_valid/req_ready/req_data carry command, instruction word and the
//   following instruction word; rsp_valid/rsp_ready/rsp_data carry one result each
// stages: a request is registered into execute, its result into writeback, which
//   offers it (register read, then execute; loads finish from the data memory output)
// throughput: one instruction per cycle while results are taken; register reads
//   go to the two-port register file at request time and are forwarded from the two
//   most recent writes; a load reads or a store writes data memory in its execute cycle
// stall: a result held by rsp_ready low freezes the whole pipeline, so
//   req_ready follows rsp_ready while a result is waiting
// reset: registers, pc and the halted flag clear at once; the data memory is
//   zeroed by a sweep of all DATA_DEPTH entries after reset, with req_ready low
// after HLT or an illegal command every later request returns the held pc, the status
//   that halted it and no writes
// depends on tie_pkg, tie_regfile, tie_dmem
module tiny_isa_execute_unit #(
   parameter int DATA_DEPTH = tie_pkg::DATA_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tie_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tie_pkg::rsp_type rsp_data
);
   import tie_pkg::*;

   logic adv;
   logic acc;
   logic dmem_ready;

   // request side register addresses
   logic [RIDX_W-1:0] q_addr0;
   logic [RIDX_W-1:0] q_addr1;

   logic [WORD_W-1:0] rf_rd0;
   logic [WORD_W-1:0] rf_rd1;
   rf_wr_type         rf_wr;

   // execute stage
   logic              e_v_ff;
   req_type           e_item_ff;
   logic [RIDX_W-1:0] e_ra;
   logic [RIDX_W-1:0] e_rb;
   logic [RIDX_W-1:0] e_rc;
   logic [RIDX_W-1:0] e_addr0;
   logic [RIDX_W-1:0] e_addr1;
   logic [WORD_W-1:0] op0;
   logic [WORD_W-1:0] op1;

   // architectural state
   logic [WORD_W-1:0] pc_ff;
   logic [WORD_W-1:0] pc_in;
   logic              halted_ff;
   logic              halted_in;
   stat_type          cause_ff;
   stat_type          cause_in;

   rsp_type           res;
   logic              res_ld;
   dmem_req_type      dreq;
   logic [WORD_W-1:0] dmem_rd;

   // writeback / output stage
   logic              w_v_ff;
   rsp_type           w_rsp_ff;
   logic              w_ld_ff;
   logic [WORD_W-1:0] w_val;

   // write retired at the last edge, missed by the read taken at that edge
   logic              r_v_ff;
   logic [RIDX_W-1:0] r_idx_ff;
   logic [WORD_W-1:0] r_val_ff;

   assign adv       = !w_v_ff || rsp_ready;
   assign req_ready = adv && dmem_ready;
   assign acc       = req_valid && req_ready;

   assign q_addr0 = (req_data.command == CMD_ST) ? req_data.instr[FA_HI:FA_LO]
                                                 : req_data.instr[FB_HI:FB_LO];
   assign q_addr1 = (req_data.command == CMD_ST) ? req_data.instr[FB_HI:FB_LO]
                                                 : req_data.instr[FC_HI:FC_LO];

   tie_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (adv),
      .rd_addr0 (q_addr0),
      .rd_addr1 (q_addr1),
      .rd_data0 (rf_rd0),
      .rd_data1 (rf_rd1),
      .wr       (rf_wr)
   );

   tie_dmem #(
      .DATA_DEPTH (DATA_DEPTH)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .req     (dreq),
      .rd_data (dmem_rd),
      .ready   (dmem_ready)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= acc;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_item_ff <= req_data;
      end
   end

   assign e_ra    = e_item_ff.instr[FA_HI:FA_LO];
   assign e_rb    = e_item_ff.instr[FB_HI:FB_LO];
   assign e_rc    = e_item_ff.instr[FC_HI:FC_LO];
   assign e_addr0 = (e_item_ff.command == CMD_ST) ? e_ra : e_rb;
   assign e_addr1 = (e_item_ff.command == CMD_ST) ? e_rb : e_rc;

   // load results come straight off the data memory output
   assign w_val = w_ld_ff ? dmem_rd : w_rsp_ff.reg_value;

   // operand forwarding: writeback stage first, then the retired write
   always_comb begin
      priority if (w_v_ff && w_rsp_ff.reg_written && w_rsp_ff.reg_index == e_addr0) begin
         op0 = w_val;
      end else if (r_v_ff && r_idx_ff == e_addr0) begin
         op0 = r_val_ff;
      end else begin
         op0 = rf_rd0;
      end
      priority if (w_v_ff && w_rsp_ff.reg_written && w_rsp_ff.reg_index == e_addr1) begin
         op1 = w_val;
      end else if (r_v_ff && r_idx_ff == e_addr1) begin
         op1 = r_val_ff;
      end else begin
         op1 = rf_rd1;
      end
   end

   always_comb begin
      res       = '0;
      res_ld    = 1'b0;
      dreq      = '0;
      pc_in     = pc_ff;
      halted_in = halted_ff;
      cause_in  = cause_ff;
      if (halted_ff) begin
         res.status = cause_ff;
      end else begin
         res.status = STAT_OK;
         unique case (e_item_ff.command)
            CMD_ADD: begin
               res.reg_written = 1'b1;
               res.reg_value   = op0 + op1;
               pc_in           = pc_ff + 16'd1;
            end
            CMD_ADI: begin
               res.reg_written = 1'b1;
               res.reg_value   = op0 + {13'd0, e_rc};
               pc_in           = pc_ff + 16'd1;
            end
            CMD_SHL: begin
               res.reg_written = 1'b1;
               res.reg_value   = {op1[WORD_W-2:0], 1'b0};
               pc_in           = pc_ff + 16'd1;
            end
            CMD_SUB: begin
               res.reg_written = 1'b1;
               res.reg_value   = op0 - op1;
               pc_in           = pc_ff + 16'd1;
            end
            CMD_BRZ: begin
               if (op0 == '0) begin
                  pc_in = pc_ff + {10'd0, e_ra, e_rc};
               end else begin
                  pc_in = pc_ff + 16'd1;
               end
            end
            CMD_JMP: begin
               pc_in = op0;
            end
            CMD_LDI: begin
               res.reg_written = 1'b1;
               res.reg_value   = {13'd0, e_rc};
               pc_in           = pc_ff + 16'd1;
            end
            CMD_LD: begin
               res.reg_written = 1'b1;
               res_ld          = 1'b1;
               dreq.rd         = adv && e_v_ff;
               dreq.addr       = op0;
               pc_in           = pc_ff + 16'd1;
            end
            CMD_SET: begin
               res.reg_written = 1'b1;
               res.reg_value   = e_item_ff.next_word;
               pc_in           = pc_ff + 16'd2;
            end
            CMD_ST: begin
               res.mem_written = 1'b1;
               res.mem_address = op0;
               res.mem_data    = op1;
               dreq.wr         = adv && e_v_ff;
               dreq.addr       = op0;
               dreq.wdata      = op1;
               pc_in           = pc_ff + 16'd1;
            end
            CMD_HLT: begin
               halted_in  = 1'b1;
               cause_in   = STAT_HALT;
               res.status = STAT_HALT;
            end
            default: begin
               halted_in  = 1'b1;
               cause_in   = STAT_ILLEGAL;
               res.status = STAT_ILLEGAL;
            end
         endcase
         if (res.reg_written) begin
            res.reg_index = e_ra;
         end
      end
      res.next_pc = pc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= '0;
         halted_ff <= 1'b0;
         cause_ff  <= STAT_OK;
      end else if (adv && e_v_ff) begin
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
         cause_ff  <= cause_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_v_ff <= 1'b0;
         r_v_ff <= 1'b0;
      end else if (adv) begin
         w_v_ff <= e_v_ff;
         r_v_ff <= w_v_ff && w_rsp_ff.reg_written;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_rsp_ff <= res;
         w_ld_ff  <= res_ld;
         r_idx_ff <= w_rsp_ff.reg_index;
         r_val_ff <= w_val;
      end
   end

   assign rf_wr.en   = adv && w_v_ff && w_rsp_ff.reg_written;
   assign rf_wr.idx  = w_rsp_ff.reg_index;
   assign rf_wr.data = w_val;

   always_comb begin
      rsp_data           = w_rsp_ff;
      rsp_data.reg_value = w_val;
   end

   assign rsp_valid = w_v_ff;

endmodule

[test/tiny_isa_execute_unit_tb.sv]
// testbench for tiny_isa_execute_unit: directed and random instruction streams,
// predicted against a behavioral copy of registers, pc and data memory
// depends on tie_pkg and the tiny_isa_execute_unit rtl
`timescale 1ns / 1ps

module tiny_isa_execute_unit_tb;
   import tie_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // behavioral machine state
   logic [WORD_W-1:0] regs [REG_COUNT];
   logic [WORD_W-1:0] data_words [DATA_DEPTH_DEF];
   logic [WORD_W-1:0] prog_counter;
   logic              halted;
   stat_type          halt_code;

   rsp_type step_outcomes [$];
   int      mismatch_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      ready_hold = 0;

   tiny_isa_execute_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_type execute_instr(input req_type rq);
      rsp_type           r;
      logic [2:0]        fa;
      logic [2:0]        fb;
      logic [2:0]        fc;
      logic [WORD_W-1:0] pc;
      r = '0;
      fa = rq.instr[FA_HI:FA_LO];
      fb = rq.instr[FB_HI:FB_LO];
      fc = rq.instr[FC_HI:FC_LO];
      pc = prog_counter;
      if (halted) begin
         r.status = halt_code;
      end else begin
         pc = prog_counter + 16'd1;
         case (rq.command)
            CMD_ADD: begin
               r.reg_written = 1'b1;
               r.reg_value = regs[fb] + regs[fc];
            end
            CMD_ADI: begin
               r.reg_written = 1'b1;
               r.reg_value = regs[fb] + {13'd0, fc};
            end
            CMD_SHL: begin
               r.reg_written = 1'b1;
               r.reg_value = {regs[fc][WORD_W-2:0], 1'b0};
            end
            CMD_SUB: begin
               r.reg_written = 1'b1;
               r.reg_value = regs[fb] - regs[fc];
            end
            CMD_BRZ: begin
               if (regs[fb] == '0) pc = prog_counter + {10'd0, fa, fc};
            end
            CMD_JMP: begin
               pc = regs[fb];
            end
            CMD_LDI: begin
               r.reg_written = 1'b1;
               r.reg_value = {13'd0, fc};
            end
            CMD_LD: begin
               r.reg_written = 1'b1;
               r.reg_value = data_words[regs[fb] % DATA_DEPTH_DEF];
            end
            CMD_SET: begin
               r.reg_written = 1'b1;
               r.reg_value = rq.next_word;
               pc = prog_counter + 16'd2;
            end
            CMD_ST: begin
               r.mem_written = 1'b1;
               r.mem_address = regs[fa];
               r.mem_data = regs[fb];
               data_words[regs[fa] % DATA_DEPTH_DEF] = regs[fb];
            end
            CMD_HLT: begin
               pc = prog_counter;
               halted = 1'b1;
               halt_code = STAT_HALT;
               r.status = STAT_HALT;
            end
            default: begin
               pc = prog_counter;
               halted = 1'b1;
               halt_code = STAT_ILLEGAL;
               r.status = STAT_ILLEGAL;
            end
         endcase
         if (r.reg_written) begin
            r.reg_index = fa;
            regs[fa] = r.reg_value;
         end
         prog_counter = pc;
      end
      r.next_pc = pc;
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [WORD_W-1:0] want,
                                         input logic [WORD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (step_outcomes.size() == 0) begin
               $display("%0t: result with none pending expected none actual %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = step_outcomes.pop_front();
               compare_field("next_pc", want.next_pc, rsp_data.next_pc);
               compare_field("status", 16'(want.status), 16'(rsp_data.status));
               compare_field("reg_written", 16'(want.reg_written), 16'(rsp_data.reg_written));
               compare_field("reg_index", 16'(want.reg_index), 16'(rsp_data.reg_index));
               compare_field("reg_value", want.reg_value, rsp_data.reg_value);
               compare_field("mem_written", 16'(want.mem_written), 16'(rsp_data.mem_written));
               compare_field("mem_address", want.mem_address, rsp_data.mem_address);
               compare_field("mem_data", want.mem_data, rsp_data.mem_data);
            end
         end
         if (req_valid && req_ready) step_outcomes.push_back(execute_instr(req_data));
      end
   end

   // receiver side: random stalls, or a forced hold-off when requested
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_instr(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic issue(input logic [3:0] op, input logic [2:0] fa, input logic [2:0] fb,
                        input logic [2:0] fc, input logic [WORD_W-1:0] nw);
      req_type item;
      item.command = op;
      item.instr = {7'($urandom), fa, fb, fc};
      item.next_word = nw;
      send_instr(item);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (step_outcomes.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      issue(CMD_SET, 3'd1, 3'd0, 3'd0, 16'hFFFF);
      issue(CMD_SET, 3'd2, 3'd0, 3'd0, 16'h0001);
      issue(CMD_SET, 3'd0, 3'd0, 3'd0, 16'h8000);
      issue(CMD_ADD, 3'd3, 3'd1, 3'd2, 16'h0000);   // wraps to zero
      issue(CMD_ADI, 3'd4, 3'd1, 3'd7, 16'hFFFF);
      issue(CMD_SHL, 3'd5, 3'd3, 3'd0, 16'h0000);   // top bit shifted out
      issue(CMD_SUB, 3'd6, 3'd3, 3'd2, 16'h0000);   // borrow
      issue(CMD_LDI, 3'd7, 3'd7, 3'd7, 16'h0000);
      issue(CMD_LDI, 3'd7, 3'd0, 3'd0, 16'h0000);
      issue(CMD_BRZ, 3'd7, 3'd3, 3'd7, 16'h0000);   // taken, largest offset
      issue(CMD_BRZ, 3'd7, 3'd1, 3'd7, 16'h0000);   // not taken
      issue(CMD_BRZ, 3'd0, 3'd3, 3'd0, 16'h0000);   // taken, zero offset
      issue(CMD_ST, 3'd1, 3'd6, 3'd0, 16'h0000);    // top address, aliases the last data word
      issue(CMD_SET, 3'd4, 3'd0, 3'd0, 16'h03FF);
      issue(CMD_LD, 3'd5, 3'd4, 3'd0, 16'h0000);
      issue(CMD_LD, 3'd5, 3'd2, 3'd0, 16'h0000);    // never stored
      issue(CMD_ST, 3'd3, 3'd0, 3'd0, 16'h0000);
      issue(CMD_LD, 3'd7, 3'd3, 3'd0, 16'h0000);
      issue(CMD_JMP, 3'd0, 3'd1, 3'd0, 16'h0000);
      issue(CMD_ADD, 3'd0, 3'd0, 3'd0, 16'h0000);   // pc wraps to zero
      issue(CMD_JMP, 3'd0, 3'd6, 3'd0, 16'h0000);
      issue(CMD_SET, 3'd3, 3'd0, 3'd0, 16'h0000);   // pc + 2 wraps
      wait_results_drained();
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      req_type item;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) begin
         if ($urandom_range(0, 99) < 20) item.command = CMD_SET;
         else item.command = 4'($urandom_range(0, 9));
         item.instr = 16'($urandom);
         case ($urandom_range(0, 2))
            0: item.next_word = 16'($urandom);
            1: item.next_word = 16'($urandom_range(0, 15));
            default: item.next_word = {6'($urandom), 10'($urandom_range(0, 7))};
         endcase
         send_instr(item);
      end
      wait_results_drained();
   endtask

   // long receiver hold-off so the pipeline fills and stalls its input
   task automatic test_backpressure();
      req_type item;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      ready_hold <= 80;
      repeat (30) begin
         item.command = 4'($urandom_range(0, 9));
         item.instr = 16'($urandom);
         item.next_word = 16'($urandom);
         send_instr(item);
      end
      wait_results_drained();
   endtask

   // halt once, then every command while halted
   task automatic test_halt();
      logic [3:0] stop_op;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      if ($urandom_range(0, 1) == 0) stop_op = CMD_HLT;
      else stop_op = 4'($urandom_range(11, 15));
      issue(stop_op, 3'($urandom), 3'($urandom), 3'($urandom), 16'($urandom));
      for (int op = 0; op < 16; op++)
         issue(4'(op), 3'($urandom), 3'($urandom), 3'($urandom), 16'($urandom));
      wait_results_drained();
   endtask

   initial begin
      foreach (regs[i]) regs[i] = '0;
      foreach (data_words[i]) data_words[i] = '0;
      prog_counter = '0;
      halted = 1'b0;
      halt_code = STAT_OK;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(195, 9, 83);
      test_backpressure();
      test_random(195, 83, 9);
      test_random(195, 0, 0);
      test_halt();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && step_outcomes.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("simulation failed");
      $finish;
   end

endmodule
